FILE: rtl/core/lor_pkg.sv
package lor_pkg;

    localparam int COORD_BITS  = 6;
    localparam int DELTA_BITS  = COORD_BITS + 1;
    localparam int TWICE_BITS  = COORD_BITS + 2;
    localparam int ERR_BITS    = 2 * COORD_BITS + 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [DELTA_BITS-1:0] delta_t;
    typedef logic [TWICE_BITS-1:0] twice_t;
    typedef logic [ERR_BITS-1:0]   err_t;

    typedef enum logic [1:0] {
        OCT_SHALLOW_POS = 2'd0,
        OCT_STEEP_POS   = 2'd1,
        OCT_STEEP_NEG   = 2'd2,
        OCT_SHALLOW_NEG = 2'd3
    } octant_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_RUN  = 1'b1
    } back_state_t;

    typedef struct packed {
        octant_t octant;
        coord_t  x_start;
        coord_t  y_start;
        delta_t  err_init;
        twice_t  twice_major;
        twice_t  twice_minor;
        coord_t  steps;
    } line_job_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    function automatic delta_t coord_diff(input coord_t a, input coord_t b);
        return delta_t'({1'b0, a}) - delta_t'({1'b0, b});
    endfunction

    function automatic delta_t major_steps(input octant_t oct, input delta_t dx,
                                           input delta_t dy);
        delta_t s;
        case (oct)
            OCT_SHALLOW_POS: s = dx;
            OCT_SHALLOW_NEG: s = delta_t'(-dx);
            default:         s = dy;
        endcase
        return s;
    endfunction

    function automatic logic line_empty(input delta_t steps);
        return steps[DELTA_BITS-1] || (steps == '0);
    endfunction

endpackage

FILE: rtl/core/lor_front.sv
module lor_front
    import lor_pkg::*;
(
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    mode,
    input  coord_t        x_start,
    input  coord_t        y_start,
    input  coord_t        x_end,
    input  coord_t        y_end,
    input  queue_status_t q_status,
    output logic          push,
    output line_job_t     job
);

    octant_t oct;
    delta_t  dx;
    delta_t  dy;
    delta_t  steps;
    logic    shallow;

    always_comb
    begin
        oct     = octant_t'(mode);
        dx      = coord_diff(x_end, x_start);
        dy      = coord_diff(y_end, y_start);
        steps   = major_steps(oct, dx, dy);
        shallow = (oct == OCT_SHALLOW_POS) || (oct == OCT_SHALLOW_NEG);

        job.octant      = oct;
        job.x_start     = x_start;
        job.y_start     = y_start;
        job.steps       = steps[COORD_BITS-1:0];
        job.err_init    = shallow ? dx : dy;
        job.twice_major = shallow ? {dx, 1'b0} : {dy, 1'b0};
        job.twice_minor = shallow ? {dy, 1'b0} : {dx, 1'b0};
    end

    // accept every command while there is room; drop empty or backward lines
    assign in_ready = !q_status.full;
    assign push     = in_valid && in_ready && !line_empty(steps);

endmodule

FILE: rtl/core/lor_queue.sv
module lor_queue
    import lor_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  line_job_t     push_job,
    input  logic          pop,
    output line_job_t     head_job,
    output queue_status_t status
);

    line_job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg;
    logic [QPTR_BITS-1:0]   wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg;
    logic [QPTR_BITS-1:0]   rd_ptr_next;
    logic [QCNT_BITS-1:0]   count_reg;
    logic [QCNT_BITS-1:0]   count_next;
    logic                   do_push;
    logic                   do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_job     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QPTR_BITS'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QPTR_BITS'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_BITS'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: rtl/core/lor_back.sv
module lor_back
    import lor_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_status_t q_status,
    input  line_job_t     head_job,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output coord_t        pixel_x,
    output coord_t        pixel_y,
    output logic          last
);

    back_state_t state_reg;
    back_state_t state_next;
    octant_t     octant_reg;
    coord_t      cur_x_reg;
    coord_t      cur_x_next;
    coord_t      cur_y_reg;
    coord_t      cur_y_next;
    err_t        err_reg;
    err_t        err_next;
    err_t        err_moved;
    err_t        twice_major_ext;
    err_t        twice_minor_ext;
    twice_t      twice_major_reg;
    twice_t      twice_minor_reg;
    coord_t      remain_reg;
    logic        out_valid_reg;
    coord_t      pixel_x_reg;
    coord_t      pixel_y_reg;
    logic        last_reg;
    logic        out_free;
    logic        advance;
    logic        final_pixel;
    logic        step_minor;

    assign out_free    = !out_valid_reg || out_ready;
    assign final_pixel = (remain_reg == COORD_BITS'(1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = BK_RUN;
                end
            end
            BK_RUN:
            begin
                if (out_free && final_pixel)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop     = 1'b0;
        advance = 1'b0;
        case (state_reg)
            BK_IDLE: pop     = !q_status.empty;
            BK_RUN:  advance = out_free;
            default:
            begin
                pop     = 1'b0;
                advance = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        twice_major_ext = {{(ERR_BITS-TWICE_BITS){twice_major_reg[TWICE_BITS-1]}},
                           twice_major_reg};
        twice_minor_ext = {{(ERR_BITS-TWICE_BITS){twice_minor_reg[TWICE_BITS-1]}},
                           twice_minor_reg};
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        case (octant_reg)
            OCT_SHALLOW_POS:
            begin
                err_moved  = err_reg - twice_minor_ext;
                step_minor = err_moved[ERR_BITS-1];
                cur_x_next = cur_x_reg + COORD_BITS'(1);
                cur_y_next = cur_y_reg + COORD_BITS'(step_minor);
            end
            OCT_STEEP_POS:
            begin
                err_moved  = err_reg - twice_minor_ext;
                step_minor = err_moved[ERR_BITS-1];
                cur_y_next = cur_y_reg + COORD_BITS'(1);
                cur_x_next = cur_x_reg + COORD_BITS'(step_minor);
            end
            OCT_STEEP_NEG:
            begin
                err_moved  = err_reg + twice_minor_ext;
                step_minor = err_moved[ERR_BITS-1] || (err_moved == '0);
                cur_y_next = cur_y_reg + COORD_BITS'(1);
                cur_x_next = cur_x_reg - COORD_BITS'(step_minor);
            end
            default:
            begin
                err_moved  = err_reg + twice_minor_ext;
                step_minor = !err_moved[ERR_BITS-1];
                cur_x_next = cur_x_reg - COORD_BITS'(1);
                cur_y_next = cur_y_reg + COORD_BITS'(step_minor);
            end
        endcase
        err_next = step_minor ? err_moved + twice_major_ext : err_moved;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            octant_reg      <= head_job.octant;
            cur_x_reg       <= head_job.x_start;
            cur_y_reg       <= head_job.y_start;
            err_reg         <= {{(ERR_BITS-DELTA_BITS){head_job.err_init[DELTA_BITS-1]}},
                                head_job.err_init};
            twice_major_reg <= head_job.twice_major;
            twice_minor_reg <= head_job.twice_minor;
            remain_reg      <= head_job.steps;
        end
        else if (advance)
        begin
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            err_reg    <= err_next;
            remain_reg <= remain_reg - COORD_BITS'(1);
        end
        if (advance)
        begin
            pixel_x_reg <= cur_x_reg;
            pixel_y_reg <= cur_y_reg;
            last_reg    <= final_pixel;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_x   = pixel_x_reg;
    assign pixel_y   = pixel_y_reg;
    assign last      = last_reg;

endmodule

FILE: rtl/core/line_octant_rasterizer.sv
// Path: a command beat is written into the queue, loaded into the stepper, and
// stepped into the pixel output register. Throughput: one pixel per cycle while
// out_ready is high; each line takes a load step first, then one step per pixel.
// A two-entry command queue lets commands be taken while a line is drawn.
// Reset: rst_n is asynchronous, active low; it empties the queue, idles the
// stepper and drops any pending pixel.
module line_octant_rasterizer
    import lor_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] mode,
    input  coord_t     x_start,
    input  coord_t     y_start,
    input  coord_t     x_end,
    input  coord_t     y_end,
    output logic       out_valid,
    input  logic       out_ready,
    output coord_t     pixel_x,
    output coord_t     pixel_y,
    output logic       last
);

    queue_status_t q_status;
    line_job_t     push_job;
    line_job_t     head_job;
    logic          push;
    logic          pop;

    lor_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .x_start  (x_start),
        .y_start  (y_start),
        .x_end    (x_end),
        .y_end    (y_end),
        .q_status (q_status),
        .push     (push),
        .job      (push_job)
    );

    lor_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    lor_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .head_job  (head_job),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .last      (last)
    );

endmodule

FILE: rtl/core/lor_checker.sv
module lor_checker
    import lor_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] mode,
    input coord_t     x_start,
    input coord_t     y_start,
    input coord_t     x_end,
    input coord_t     y_end,
    input logic       out_valid,
    input logic       out_ready,
    input coord_t     pixel_x,
    input coord_t     pixel_y,
    input logic       last
);

    logic       in_beat;
    logic       out_beat;
    logic       in_line;
    delta_t     steps;
    logic [3:0] pending_reg;
    logic       have_prev_reg;
    logic       prev_last_reg;
    coord_t     prev_x_reg;
    coord_t     prev_y_reg;
    coord_t     move_x;
    coord_t     move_y;
    logic       near_x;
    logic       near_y;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;
    assign steps    = major_steps(octant_t'(mode), coord_diff(x_end, x_start),
                                  coord_diff(y_end, y_start));
    assign in_line  = in_beat && !line_empty(steps);
    assign move_x   = pixel_x - prev_x_reg;
    assign move_y   = pixel_y - prev_y_reg;
    assign near_x   = (move_x == '0) || (move_x == COORD_BITS'(1)) || (move_x == '1);
    assign near_y   = (move_y == '0) || (move_y == COORD_BITS'(1)) || (move_y == '1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            have_prev_reg <= 1'b0;
            prev_last_reg <= 1'b1;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 4'(in_line) - 4'(out_beat && last);
            if (out_beat)
            begin
                have_prev_reg <= 1'b1;
                prev_last_reg <= last;
                prev_x_reg    <= pixel_x;
                prev_y_reg    <= pixel_y;
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_x)
                                    && $stable(pixel_y) && $stable(last))
        else $error("pixel beat changed while stalled");

    a_out_owned: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != '0)
        else $error("pixel beat without an open line");

    a_step_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat && have_prev_reg && !prev_last_reg
            |-> near_x && near_y && !(move_x == '0 && move_y == '0))
        else $error("pixels of one line are not adjacent");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 4'(QUEUE_DEPTH + 2))
        else $error("more lines open than the block can hold");

endmodule

bind line_octant_rasterizer lor_checker u_lor_checker (.*);
